[hdl/mrg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared types and constants of the multiple recursive generator.
// ----------------------------------------------------------------------------
package mrg_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ORDER_W   = 3;
  localparam int unsigned NCOEF     = 4;

  localparam logic [CFG_IDX_W-1:0] IDX_MODULUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_ORDER   = 3'd1;
  localparam int unsigned          IDX_COEF0   = 2;

  // input item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RED  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DONE = 5'b10000
  } mrg_state_e;

  typedef struct packed {
    logic capture;      // latch the input item, restart counters
    logic red_step;     // one bit of operand reduction
    logic mul_step;     // one bit of modular multiply
    logic acc_step;     // add product into the sum, advance tap
    logic push_seed;    // shift reduced seed into history
    logic push_result;  // shift negated sum into history and output register
  } mrg_cmd_t;

  typedef struct packed {
    logic func;      // function of the captured item
    logic bit_last;  // bit counter at bit zero
    logic tap_last;  // tap counter at the last tap of the order
    logic out_busy;  // output register holds a result not taken this cycle
  } mrg_status_t;

endpackage
`default_nettype wire

[hdl/mrg_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_in_if
// Input channel: load or step items with a seed value.
// ----------------------------------------------------------------------------
interface mrg_in_if #(
  parameter int unsigned VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [VALUE_BITS-1:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface
`default_nettype wire

[hdl/mrg_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_out_if
// Output channel: generated sequence values.
// ----------------------------------------------------------------------------
interface mrg_out_if #(
  parameter int unsigned VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[hdl/mrg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_ctrl
// Sequencer: reduce operand; for step items multiply bit by bit and accumulate per tap; finish.
// ----------------------------------------------------------------------------
module mrg_ctrl
  import mrg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mrg_status_t status_i,
  output mrg_cmd_t         cmd_o
);

  mrg_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (status_i.bit_last) begin
          state_d = (status_i.func == FUNC_STEP) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.bit_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d        = status_i.tap_last ? ST_DONE : ST_RED;
      end
      ST_DONE: begin
        if (status_i.func == FUNC_LOAD) begin
          cmd_o.push_seed = 1'b1;
          state_d         = ST_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.push_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[hdl/mrg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_dp
// Datapath: configuration, history, bit-serial modular reduce and multiply.
// ----------------------------------------------------------------------------
module mrg_dp
  import mrg_pkg::*;
#(
  parameter int unsigned TAPS       = 4,
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned CFG_W      = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic                  func_i,
  input  wire logic [VALUE_BITS-1:0] seed_value_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [VALUE_BITS-1:0]      value_o,
  input  wire mrg_cmd_t              cmd_i,
  output mrg_status_t                status_o
);

  localparam int unsigned TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned BW    = $clog2(VALUE_BITS);
  localparam int unsigned ORD_W = ($clog2(TAPS + 1) > ORDER_W) ? $clog2(TAPS + 1) : ORDER_W;
  localparam int unsigned VB    = VALUE_BITS;

  // configuration
  logic [VB-1:0]    modulus_q;
  logic [ORD_W-1:0] order_q;
  logic [VB-1:0]    coef_q [TAPS];

  // state and working registers
  logic [VB-1:0] hist_q [TAPS];
  logic          func_q;
  logic [VB-1:0] seed_q;
  logic [VB-1:0] red_q, red_d;
  logic [VB-1:0] prod_q, prod_d;
  logic [VB-1:0] acc_q, acc_d;
  logic [BW-1:0] bit_q;
  logic [TW-1:0] tap_q;
  logic          out_valid_q;
  logic [VB-1:0] value_q;

  logic [VB-1:0] p;
  logic [VB:0]   p_x;
  logic [TW-1:0] k_last;
  logic [TW-1:0] hidx;
  logic          first;
  logic [VB-1:0] red_src;
  logic [VB:0]   red_x;
  logic [VB:0]   dbl_x;
  logic [VB-1:0] dbl;
  logic [VB:0]   mac_x;
  logic [VB:0]   sum_x;
  logic [VB-1:0] neg;

  assign p   = (modulus_q < VB'(2)) ? VB'(2) : modulus_q;
  assign p_x = {1'b0, p};

  always_comb begin
    if (order_q == '0) begin
      k_last = '0;
    end else if (order_q > ORD_W'(TAPS)) begin
      k_last = TW'(TAPS - 1);
    end else begin
      k_last = TW'(order_q - 1'b1);
    end
  end

  // tap i of the order reads the history at TAPS-k+i
  assign hidx  = TW'(TAPS - 1) - k_last + tap_q;
  assign first = (bit_q == BW'(VB - 1));

  // operand reduction, msb first: r = 2r + bit, minus p when over
  assign red_src = (func_q == FUNC_LOAD) ? seed_q : coef_q[tap_q];
  assign red_x   = {(first ? '0 : red_q), red_src[bit_q]};
  assign red_d   = (red_x >= p_x) ? red_x[VB-1:0] - p : red_x[VB-1:0];

  // multiply by history value, msb first: r = 2r + bit * a, both steps mod p
  assign dbl_x  = {(first ? '0 : prod_q), 1'b0};
  assign dbl    = (dbl_x >= p_x) ? dbl_x[VB-1:0] - p : dbl_x[VB-1:0];
  assign mac_x  = {1'b0, dbl} + (hist_q[hidx][bit_q] ? {1'b0, red_q} : '0);
  assign prod_d = (mac_x >= p_x) ? mac_x[VB-1:0] - p : mac_x[VB-1:0];

  assign sum_x = {1'b0, (tap_q == '0) ? '0 : acc_q} + {1'b0, prod_q};
  assign acc_d = (sum_x >= p_x) ? sum_x[VB-1:0] - p : sum_x[VB-1:0];

  assign neg = (acc_q == '0) ? '0 : p - acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '1;
      order_q   <= ORD_W'(TAPS);
      for (int i = 0; i < TAPS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == IDX_MODULUS) begin
        modulus_q <= cfg_data_i[VB-1:0];
      end
      if (cfg_idx_i == IDX_ORDER) begin
        order_q <= ORD_W'(cfg_data_i[ORDER_W-1:0]);
      end
      for (int i = 0; i < TAPS; i++) begin
        if ((i < NCOEF) && (cfg_idx_i == CFG_IDX_W'(IDX_COEF0 + i))) begin
          coef_q[i] <= cfg_data_i[VB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q      <= FUNC_LOAD;
      bit_q       <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        func_q <= func_i;
        bit_q  <= BW'(VB - 1);
        tap_q  <= '0;
      end
      if (cmd_i.red_step || cmd_i.mul_step) begin
        bit_q <= (bit_q == '0) ? BW'(VB - 1) : bit_q - 1'b1;
      end
      if (cmd_i.acc_step) begin
        tap_q <= tap_q + 1'b1;
      end
      if (cmd_i.push_seed || cmd_i.push_result) begin
        for (int i = 0; i + 1 < TAPS; i++) begin
          hist_q[i] <= hist_q[i + 1];
        end
        hist_q[TAPS - 1] <= cmd_i.push_seed ? red_q : neg;
      end
      if (cmd_i.push_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seed_q <= seed_value_i;
    end
    if (cmd_i.red_step) begin
      red_q <= red_d;
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_step) begin
      acc_q <= acc_d;
    end
    if (cmd_i.push_result) begin
      value_q <= neg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  assign status_o.func     = func_q;
  assign status_o.bit_last = (bit_q == '0);
  assign status_o.tap_last = (tap_q == k_last);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

[hdl/multiple_recursive_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiple_recursive_generator_core
// Linear recurrence modulo a configurable prime, one item at a time.
// ----------------------------------------------------------------------------
// step item: one result from transfer, computed over k taps, k the order;
//   each tap runs a bit-serial reduce and a bit-serial multiply, both mod p
// load item: no result; next transfer right after either
// the output register lets a new item in while a result waits
// reset: configuration to defaults, history cleared at once, no clearing pass
module multiple_recursive_generator_core
  import mrg_pkg::*;
#(
  parameter int unsigned TAPS       = 4,
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [((VALUE_BITS > ORDER_W) ? VALUE_BITS : ORDER_W)-1:0] cfg_data_i,
  mrg_in_if.sink                     in_i,
  mrg_out_if.source                  out_o
);

  localparam int unsigned CFG_W = (VALUE_BITS > ORDER_W) ? VALUE_BITS : ORDER_W;

  mrg_cmd_t    cmd;
  mrg_status_t status;

  mrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrg_dp #(
    .TAPS       (TAPS),
    .VALUE_BITS (VALUE_BITS),
    .CFG_W      (CFG_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (in_i.func),
    .seed_value_i (in_i.seed_value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .value_o      (out_o.value),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  // at most one datapath operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.red_step, cmd.mul_step, cmd.acc_step,
              cmd.push_seed, cmd.push_result}))
    else $error("more than one datapath command at once");

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_result |-> !status.out_busy && status.func == FUNC_STEP)
    else $error("result pushed into a busy output register");

  // no transfer is taken while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.red_step || cmd.mul_step || cmd.acc_step) |-> !in_i.ready)
    else $error("input ready during computation");

  // a load item never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_seed |=> !$rose(out_o.valid))
    else $error("load item produced a result");

endmodule
`default_nettype wire
